// File: rtl/core/pcrc16_pkg.sv
// package: constants, types and the crc byte fold for the packet crc-16 generator
`default_nettype none

package pcrc16_pkg;

    // crc-16/umts parameters
    localparam logic [15:0] CRC_POLY = 16'h8005;
    localparam logic [15:0] CRC_INIT = 16'h0000;

    // packet layout
    localparam int unsigned IDX_W = 17;
    localparam int unsigned LEN_W = 16;
    localparam logic [IDX_W-1:0] HDR_LAST_IDX = 17'd4;
    localparam logic [IDX_W-1:0] LEN_LO_IDX = 17'd5;
    localparam logic [IDX_W-1:0] LEN_HI_IDX = 17'd6;
    localparam logic [LEN_W-1:0] LEN_MIN = 16'd2;

    // one processed byte as seen by the output stage
    typedef struct packed {
        logic        done;
        logic [15:0] crc;
        logic        length_error;
    } t_result;

    // fold one byte into the crc, msb first
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/pcrc16_if.sv
// interfaces: byte request channel and crc result channel
`default_nettype none

interface pcrc16_req_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       packet_start;

    modport source (output valid, output data_byte, output packet_start, input ready);
    modport sink (input valid, input data_byte, input packet_start, output ready);
endinterface

interface pcrc16_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] crc_low;
    logic [7:0] crc_high;
    logic       length_error;

    modport source (output valid, output crc_low, output crc_high, output length_error,
                    input ready);
    modport sink (input valid, input crc_low, input crc_high, input length_error,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/core/pcrc16_engine.sv
// packet state tracker: byte index, length field and running crc
`default_nettype none

module pcrc16_engine (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_fire,
    input  wire logic [7:0]          i_data_byte,
    input  wire logic                i_packet_start,
    output pcrc16_pkg::t_result      o_res
);

    logic [15:0]                       r_crc;
    logic [pcrc16_pkg::IDX_W-1:0]      r_byte_index;
    logic [pcrc16_pkg::LEN_W-1:0]      r_length;
    logic                              r_in_packet;

    logic [15:0]                       n_crc;
    logic [pcrc16_pkg::IDX_W-1:0]      n_byte_index;
    logic [pcrc16_pkg::LEN_W-1:0]      n_length;
    logic                              w_active;
    logic                              w_short;
    logic                              w_done;
    logic [pcrc16_pkg::IDX_W-1:0]      w_last_idx;

    // effective state for this byte, a start opens a fresh packet
    always_comb begin
        n_crc        = pcrc16_pkg::crc_fold(i_packet_start ? pcrc16_pkg::CRC_INIT : r_crc,
                                            i_data_byte);
        n_byte_index = i_packet_start ? '0 : r_byte_index;
        n_length     = i_packet_start ? '0 : r_length;
        if (n_byte_index == pcrc16_pkg::LEN_LO_IDX) begin
            n_length[7:0] = i_data_byte;
        end else if (n_byte_index == pcrc16_pkg::LEN_HI_IDX) begin
            n_length[15:8] = i_data_byte;
        end
        w_active   = i_packet_start | r_in_packet;
        w_last_idx = pcrc16_pkg::HDR_LAST_IDX + {1'b0, n_length};
        w_short    = (n_byte_index == pcrc16_pkg::LEN_HI_IDX) && (n_length < pcrc16_pkg::LEN_MIN);
        w_done     = w_active && (w_short ||
                     ((n_byte_index >= pcrc16_pkg::LEN_HI_IDX) && (n_byte_index == w_last_idx)));
    end

    // result of this byte
    always_comb begin
        o_res.done         = w_done;
        o_res.crc          = n_crc;
        o_res.length_error = w_short;
    end

    // packet state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc        <= '0;
            r_byte_index <= '0;
            r_length     <= '0;
            r_in_packet  <= 1'b0;
        end else if (i_fire && w_active) begin
            r_crc        <= n_crc;
            r_length     <= n_length;
            r_in_packet  <= !w_done;
            r_byte_index <= w_done ? n_byte_index : n_byte_index + 1'b1;
        end
    end

    // idle bytes never finish a packet
    a_idle_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_in_packet && !i_packet_start) |-> !o_res.done)
        else $error("result produced while idle");

    // length error only on the high length byte
    a_err_at_len_hi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_active && o_res.length_error) |-> (n_byte_index == pcrc16_pkg::LEN_HI_IDX))
        else $error("length error away from length byte");

    // a finished packet closes
    a_done_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_res.done) |=> !r_in_packet)
        else $error("packet still open after result");

endmodule

`default_nettype wire

// File: rtl/core/packet_crc16_generator_core.sv
// top level: packet crc-16 generator with registered input and result stages
// path: the request carrying the last covered byte is held in the input register, then its result is registered
// throughput: one byte per cycle, set by the combinational crc fold and the registered state update
// a result waiting at the output stalls further bytes only when another result is due
// reset: synchronous active-low i_rst_n clears crc, byte index, length and the open flag
// after reset the block is idle and ignores bytes until one carries packet_start
`default_nettype none

module packet_crc16_generator_core (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    pcrc16_req_if.sink     i_req,
    pcrc16_res_if.source   o_res
);

    logic        r_in_vld;
    logic [7:0]  r_in_data;
    logic        r_in_start;
    logic        r_out_vld;
    logic [15:0] r_out_crc;
    logic        r_out_err;

    logic                 w_out_free;
    logic                 w_fire;
    pcrc16_pkg::t_result  w_res;

    // stage handshake
    assign w_out_free  = !r_out_vld || o_res.ready;
    assign w_fire      = r_in_vld && (!w_res.done || w_out_free);
    assign i_req.ready = !r_in_vld || w_fire;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_req.ready) begin
            r_in_vld <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_in_data  <= i_req.data_byte;
            r_in_start <= i_req.packet_start;
        end
    end

    // packet state and crc
    pcrc16_engine u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (w_fire),
        .i_data_byte    (r_in_data),
        .i_packet_start (r_in_start),
        .o_res          (w_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_fire && w_res.done) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_res.done) begin
            r_out_crc <= w_res.crc;
            r_out_err <= w_res.length_error;
        end
    end

    assign o_res.valid        = r_out_vld;
    assign o_res.crc_low      = r_out_crc[7:0];
    assign o_res.crc_high     = r_out_crc[15:8];
    assign o_res.length_error = r_out_err;

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !o_res.ready) |-> !(w_fire && w_res.done))
        else $error("pending result overwritten");

    // a new result comes only from a processed byte
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(w_fire && w_res.done))
        else $error("result without a finishing byte");

    // a held byte that finishes nothing never blocks the request side
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !w_res.done) |-> i_req.ready)
        else $error("request stalled without a pending result");

endmodule

`default_nettype wire
